// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the LED fade core.
// Uses clk and rst_n from the scope of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== hdl/lbf_pkg.sv =====
// Types and constants of the LED brightness fade core.
// No dependencies; used by lbf_div and led_brightness_fade_ramp_core.
package lbf_pkg;

    localparam int DIV_W = 16;
    localparam int LEVEL_W = 8;
    localparam int DUR_W = 16;
    localparam logic [DUR_W-1:0] MAX_DUR_RESET = 16'd10000;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_CHAN  = 3'd1,
        STAT_ABOVE_TGT = 3'd2,
        STAT_TOO_LONG  = 3'd3,
        STAT_BUSY      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_STEPS,
        S_DIV_SIZE,
        S_EMIT
    } state_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

endpackage

// ===== hdl/led_brightness_fade_ramp_core.sv =====
// Top level of the two-channel LED brightness fade core; uses lbf_pkg and lbf_div.
// One transaction is in work at a time. A tick, a rejected start or a short start
// passes through the evaluate and emit states, and the next input is accepted once
// the core is back in idle. A start that runs a fade goes twice through the
// bit-serial divider, once for the step count and once for the step size, before
// its result is emitted. While the output register still holds an unaccepted
// result, the new result waits and no input is taken until the output is free.
`include "assert_macros.svh"

module led_brightness_fade_ramp_core #(
    parameter int TICK_MS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: channel[1:0], target_level[9:2], duration_ms[25:10], zero[31:26].
    input  logic [31:0] s_axis_tdata,
    // tuser: command[0].
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[2:0], red_level[10:3], green_level[18:11], fading[19],
    // finished[20], zero[23:21].
    output logic [23:0] m_axis_tdata
);
    import lbf_pkg::*;

    localparam int TICKS_W = $clog2((2**DUR_W - 1) / TICK_MS + 1);
    localparam logic [DUR_W-1:0] TICK_VAL = DUR_W'(TICK_MS);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [1:0]           chan_reg, chan_next;
    logic [LEVEL_W-1:0]   tgt_reg, tgt_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;
    status_t              status_reg, status_next;
    logic                 finished_reg, finished_next;
    logic [LEVEL_W-1:0]   red_duty_reg, red_duty_next;
    logic [LEVEL_W-1:0]   green_duty_reg, green_duty_next;
    logic                 fade_active_reg, fade_active_next;
    logic                 fade_channel_reg, fade_channel_next;
    logic [LEVEL_W-1:0]   step_size_reg, step_size_next;
    logic [TICKS_W-1:0]   ticks_left_reg, ticks_left_next;
    logic [LEVEL_W-1:0]   fade_target_reg, fade_target_next;
    logic [TICKS_W-1:0]   steps_reg, steps_next;
    logic [DUR_W-1:0]     max_dur_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [23:0]          out_data_reg, out_data_next;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;
    logic [LEVEL_W-1:0]   cur_level;
    logic [LEVEL_W-1:0]   fade_level;
    logic [LEVEL_W-1:0]   new_level;
    logic [TICKS_W-1:0]   ticks_dec;

    lbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cur_level  = chan_reg[0] ? green_duty_reg : red_duty_reg;
    assign fade_level = fade_channel_reg ? green_duty_reg : red_duty_reg;
    assign ticks_dec  = ticks_left_reg - 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        chan_next         = chan_reg;
        tgt_next          = tgt_reg;
        dur_next          = dur_reg;
        status_next       = status_reg;
        finished_next     = finished_reg;
        red_duty_next     = red_duty_reg;
        green_duty_next   = green_duty_reg;
        fade_active_next  = fade_active_reg;
        fade_channel_next = fade_channel_reg;
        step_size_next    = step_size_reg;
        ticks_left_next   = ticks_left_reg;
        fade_target_next  = fade_target_reg;
        steps_next        = steps_reg;
        out_valid_next    = out_valid_reg & ~m_axis_tready;
        out_data_next     = out_data_reg;
        div_start         = 1'b0;
        new_level         = cur_level + step_size_reg;
        div_dividend      = {{(DIV_W-LEVEL_W){1'b0}}, tgt_reg - cur_level};
        div_divisor       = div_quotient;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser[0]);
                    chan_next  = s_axis_tdata[1:0];
                    tgt_next   = s_axis_tdata[9:2];
                    dur_next   = s_axis_tdata[25:10];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                div_dividend  = dur_reg;
                div_divisor   = TICK_VAL;
                status_next   = STAT_OK;
                finished_next = 1'b0;
                state_next    = S_EMIT;
                if (cmd_reg == CMD_TICK)
                begin
                    if (fade_active_reg)
                    begin
                        ticks_left_next = ticks_dec;
                        if (ticks_dec == '0)
                        begin
                            new_level        = fade_target_reg;
                            fade_active_next = 1'b0;
                            finished_next    = 1'b1;
                        end
                        else
                        begin
                            new_level = fade_level + step_size_reg;
                        end
                        if (fade_channel_reg)
                        begin
                            green_duty_next = new_level;
                        end
                        else
                        begin
                            red_duty_next = new_level;
                        end
                    end
                end
                else if (chan_reg[1])
                begin
                    status_next = STAT_BAD_CHAN;
                end
                else if (cur_level > tgt_reg)
                begin
                    status_next = STAT_ABOVE_TGT;
                end
                else if (dur_reg > max_dur_reg)
                begin
                    status_next = STAT_TOO_LONG;
                end
                else if (fade_active_reg)
                begin
                    status_next = STAT_BUSY;
                end
                else if (dur_reg < TICK_VAL)
                begin
                    finished_next = 1'b1;
                    if (chan_reg[0])
                    begin
                        green_duty_next = tgt_reg;
                    end
                    else
                    begin
                        red_duty_next = tgt_reg;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_STEPS;
                end
            end
            S_DIV_STEPS:
            begin
                if (div_done)
                begin
                    steps_next = div_quotient[TICKS_W-1:0];
                    div_start  = 1'b1;
                    state_next = S_DIV_SIZE;
                end
            end
            S_DIV_SIZE:
            begin
                if (div_done)
                begin
                    step_size_next    = div_quotient[LEVEL_W-1:0];
                    new_level         = cur_level + div_quotient[LEVEL_W-1:0];
                    fade_channel_next = chan_reg[0];
                    fade_target_next  = tgt_reg;
                    ticks_left_next   = steps_reg;
                    fade_active_next  = 1'b1;
                    if (chan_reg[0])
                    begin
                        green_duty_next = new_level;
                    end
                    else
                    begin
                        red_duty_next = new_level;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, finished_reg, fade_active_reg,
                                      green_duty_reg, red_duty_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            red_duty_reg     <= '0;
            green_duty_reg   <= '0;
            fade_active_reg  <= 1'b0;
            fade_channel_reg <= 1'b0;
            step_size_reg    <= '0;
            ticks_left_reg   <= '0;
            fade_target_reg  <= '0;
            max_dur_reg      <= MAX_DUR_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            red_duty_reg     <= red_duty_next;
            green_duty_reg   <= green_duty_next;
            fade_active_reg  <= fade_active_next;
            fade_channel_reg <= fade_channel_next;
            step_size_reg    <= step_size_next;
            ticks_left_reg   <= ticks_left_next;
            fade_target_reg  <= fade_target_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                max_dur_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        chan_reg     <= chan_next;
        tgt_reg      <= tgt_next;
        dur_reg      <= dur_next;
        status_reg   <= status_next;
        finished_reg <= finished_next;
        steps_reg    <= steps_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_PROP(a_active_has_ticks, fade_active_reg |-> (ticks_left_reg != '0),
                 "Fade running with no ticks left.")
    `ASSERT_PROP(a_red_below_target,
                 (fade_active_reg && !fade_channel_reg) |-> (red_duty_reg <= fade_target_reg),
                 "Red level passed the fade target.")
    `ASSERT_PROP(a_green_below_target,
                 (fade_active_reg && fade_channel_reg) |-> (green_duty_reg <= fade_target_reg),
                 "Green level passed the fade target.")
    `ASSERT_NEVER(a_done_fading, out_valid_reg && out_data_reg[19] && out_data_reg[20],
                  "Result flags fading and finished together.")
    `ASSERT_PROP(a_div_done_state,
                 div_done |-> (state_reg == S_DIV_STEPS || state_reg == S_DIV_SIZE),
                 "Divider finished outside a divide state.")

endmodule

// ===== hdl/lbf_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on lbf_pkg for the operand width.
module lbf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lbf_pkg::DIV_W-1:0]   dividend,
    input  logic [lbf_pkg::DIV_W-1:0]   divisor,
    output logic                        done,
    output logic [lbf_pkg::DIV_W-1:0]   quotient
);
    import lbf_pkg::*;

    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_W])
            begin
                rem_next = shifted[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            q_next   = {q_reg[DIV_W-2:0], ~trial[DIV_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for led_brightness_fade_ramp_core: a scoreboard predicts every result
// of the fade engine, and directed plus random start and tick streams run under random stalls.
// Depends on lbf_pkg and the RTL of the core only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbf_pkg::*;

    localparam int TICK_MS = 10;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        status_t    status;
        logic [7:0] red;
        logic [7:0] green;
        logic       fading;
        logic       finished;
    } fade_result_t;

    class fade_scoreboard;
        logic [15:0]  max_dur;
        logic [7:0]   red;
        logic [7:0]   green;
        bit           active;
        bit           chan;
        logic [7:0]   step;
        logic [15:0]  ticks_left;
        logic [7:0]   target;
        fade_result_t expected_q[$];
        int           errors;

        function new();
            max_dur = MAX_DUR_RESET;
            red = 0;
            green = 0;
            active = 0;
            chan = 0;
            step = 0;
            ticks_left = 0;
            target = 0;
            errors = 0;
        endfunction

        function logic [7:0] level(bit ch);
            return ch ? green : red;
        endfunction

        function void put_level(bit ch, logic [7:0] v);
            if (ch)
                green = v;
            else
                red = v;
        endfunction

        function void note_input(cmd_t cmd, logic [1:0] ch, logic [7:0] tgt, logic [15:0] dur);
            fade_result_t r;
            logic [15:0]  steps;
            logic [7:0]   cur;
            r.status = STAT_OK;
            r.finished = 1'b0;
            cur = level(ch[0]);
            if (cmd == CMD_START) begin
                if (ch > 2'd1)
                    r.status = STAT_BAD_CHAN;
                else if (cur > tgt)
                    r.status = STAT_ABOVE_TGT;
                else if (dur > max_dur)
                    r.status = STAT_TOO_LONG;
                else if (active)
                    r.status = STAT_BUSY;
                else begin
                    steps = 16'(dur / TICK_MS);
                    if (steps == 0) begin
                        put_level(ch[0], tgt);
                        r.finished = 1'b1;
                    end
                    else begin
                        step = 8'((16'(tgt) - 16'(cur)) / steps);
                        put_level(ch[0], cur + step);
                        chan = ch[0];
                        target = tgt;
                        ticks_left = steps;
                        active = 1;
                    end
                end
            end
            else if (active) begin
                ticks_left = ticks_left - 16'd1;
                if (ticks_left == 0) begin
                    put_level(chan, target);
                    active = 0;
                    r.finished = 1'b1;
                end
                else begin
                    put_level(chan, level(chan) + step);
                end
            end
            r.red = red;
            r.green = green;
            r.fading = active;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("Mismatch on %s: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] d);
            fade_result_t r;
            if (expected_q.size() == 0) begin
                $error("Result transaction 0x%06h arrived with nothing expected", d);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            compare_field("status", int'(r.status), int'(d[2:0]));
            compare_field("red_level", int'(r.red), int'(d[10:3]));
            compare_field("green_level", int'(r.green), int'(d[18:11]));
            compare_field("fading", int'(r.fading), int'(d[19]));
            compare_field("finished", int'(r.finished), int'(d[20]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    fade_scoreboard sb;
    bit             send_steady;
    bit             recv_steady;
    int             stall_cycles;

    led_brightness_fade_ramp_core #(
        .TICK_MS(TICK_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send(cmd_t cmd, logic [1:0] ch, logic [7:0] tgt, logic [15:0] dur);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {6'd0, dur, tgt, ch};
        s_axis_tuser <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(cmd, ch, tgt, dur);
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_duration(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.max_dur = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int          pick;
        int          hi;
        logic [1:0]  ch;
        logic [7:0]  cur;
        logic [7:0]  tgt;
        logic [15:0] dur;
        pick = $urandom_range(0, 99);
        if (sb.active && pick < 85) begin
            send(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)));
        end
        else if (!sb.active && pick < 70) begin
            ch = 2'($urandom_range(0, 1));
            cur = sb.level(ch[0]);
            if ($urandom_range(0, 39) == 0)
                tgt = 8'($urandom_range(cur, 255));
            else if ($urandom_range(0, 2) == 0)
                tgt = 8'((int'(cur) + $urandom_range(1, 3) > 255) ?
                         255 : int'(cur) + $urandom_range(1, 3));
            else
                tgt = cur;
            hi = (sb.max_dur < 200) ? int'(sb.max_dur) : 200;
            if (hi < 10 || $urandom_range(0, 9) == 0)
                dur = 16'($urandom_range(0, (hi < 9) ? hi : 9));
            else
                dur = 16'($urandom_range(10, hi));
            send(CMD_START, ch, tgt, dur);
        end
        else if (!sb.active && pick < 85) begin
            send(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)));
        end
        else begin
            ch = 2'($urandom_range(0, 3));
            cur = sb.level(ch[0]);
            if ($urandom_range(0, 7) == 0)
                tgt = 8'($urandom_range(0, 255));
            else
                tgt = 8'($urandom_range(0, cur));
            dur = 16'($urandom_range(0, 65535));
            if (dur <= sb.max_dur)
                dur = 16'(dur % 301);
            send(CMD_START, ch, tgt, dur);
        end
    endtask

    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n)
                break;
        end
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_steady = !recv_steady;
            if (!recv_steady) begin
                int stall;
                stall = $urandom_range(0, 19);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [15:0] phase_max [5];
        int          phase_items [5];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        stall_cycles = 0;
        send_steady = 0;
        recv_steady = 0;
        phase_max = '{16'd0, 16'd37, 16'd65535, 16'($urandom_range(10, 400)), 16'd10000};
        phase_items = '{100, 300, 300, 300, 300};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send(CMD_TICK, 2'd3, 8'd255, 16'd65535);
        send(CMD_START, 2'd2, 8'd0, 16'd0);
        send(CMD_START, 2'd3, 8'd255, 16'd65535);
        send(CMD_START, 2'd0, 8'd0, 16'd65535);
        send(CMD_START, 2'd0, 8'd40, 16'd5);
        send(CMD_START, 2'd0, 8'd10, 16'd0);
        send(CMD_START, 2'd1, 8'd200, 16'd30);
        send(CMD_START, 2'd0, 8'd50, 16'd10);
        send(CMD_START, 2'd1, 8'd255, 16'd10000);
        repeat (3) send(CMD_TICK, 2'd0, 8'd0, 16'd0);
        send(CMD_START, 2'd0, 8'd40, 16'd20);
        repeat (2) send(CMD_TICK, 2'd2, 8'd170, 16'd43690);
        send(CMD_START, 2'd0, 8'd90, 16'd25);
        repeat (2) send(CMD_TICK, 2'd1, 8'd85, 16'd21845);
        send(CMD_TICK, 2'd0, 8'd0, 16'd0);

        for (int p = 0; p < 5; p++) begin
            wait_until_drained();
            write_max_duration(phase_max[p]);
            repeat (phase_items[p]) send_random_item();
        end

        wait_until_drained();
        write_max_duration(16'hFFFF);
        send_steady = 1;
        send(CMD_START, 2'd1, 8'd255, 16'd1000);
        while (sb.active)
            send(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)));

        wait_until_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
